// ===== hw/rtl/periodic_task_tick_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler checker.
// Every macro samples on aclk; the first two hold off while aresetn is low.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PTTS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked outside reset
`define PTTS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked through reset as well
`define PTTS_ASSERT_NEXT_ALWAYS(label, pre, post) \
    label: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("scheduler check failed");

`endif

// ===== hw/rtl/ptts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; the remainder unit, slot table and top level refer to it by scoped names.
package ptts_pkg;

    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DATA_W = 32;
    localparam int MASK_W = 8;
    localparam int CNT_W  = $clog2(DATA_W + 1);

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic  valid;
        logic  action;
        data_t period;
        data_t delay;
    } slot_entry_t;

    typedef struct packed {
        logic  claim_en;
        idx_t  claim_idx;
        logic  claim_action;
        data_t claim_period;
        data_t claim_delay;
        logic  dec_en;
        idx_t  dec_idx;
        data_t dec_value;
    } tbl_cmd_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

// ===== hw/rtl/ptts_rem_unit.sv =====
// Bit-serial restoring remainder unit: tests dividend mod divisor for zero.
// Depends on ptts_pkg; one quotient bit per cycle.
module ptts_rem_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  ptts_pkg::data_t       dividend,
    input  ptts_pkg::data_t       divisor,
    output ptts_pkg::rem_status_t rem_status
);

    ptts_pkg::cnt_t  cnt_reg, cnt_next;
    logic            done_reg, done_next;
    ptts_pkg::data_t r_reg, r_next;
    ptts_pkg::data_t q_reg, q_next;
    ptts_pkg::data_t d_reg, d_next;

    logic [ptts_pkg::DATA_W:0] r_shift;
    logic [ptts_pkg::DATA_W:0] r_diff;
    logic                      r_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign r_shift = {r_reg, q_reg[ptts_pkg::DATA_W-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};
    assign r_ge    = (r_shift >= {1'b0, d_reg});

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start) begin
            cnt_next = ptts_pkg::cnt_t'(ptts_pkg::DATA_W);
            r_next   = '0;
            q_next   = dividend;
            d_next   = divisor;
        end else if (cnt_reg != '0) begin
            r_next   = r_ge ? r_diff[ptts_pkg::DATA_W-1:0]
                            : r_shift[ptts_pkg::DATA_W-1:0];
            q_next   = {q_reg[ptts_pkg::DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ptts_pkg::cnt_t'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign rem_status.done = done_reg;
    assign rem_status.zero = (r_reg == '0);

endmodule

// ===== hw/rtl/ptts_slot_table.sv =====
// Task slot table: valid bits with reset, action flag, period and delay.
// Depends on ptts_pkg; one scan read port, claim and delay-update writes.
module ptts_slot_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ptts_pkg::tbl_cmd_t    cmd,
    input  ptts_pkg::idx_t        rd_idx,
    output ptts_pkg::slot_entry_t rd_entry,
    output logic                  claim_taken
);

    logic [ptts_pkg::SLOTS-1:0] valid_reg;
    logic                       action_reg [ptts_pkg::SLOTS];
    ptts_pkg::data_t            period_reg [ptts_pkg::SLOTS];
    ptts_pkg::data_t            delay_reg  [ptts_pkg::SLOTS];

    // Valid bits clear on reset; a claimed slot stays valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.claim_en) begin
            valid_reg[cmd.claim_idx] <= 1'b1;
        end
    end

    // Payload columns: claim writes all, a countdown writes the delay
    always_ff @(posedge aclk) begin
        if (cmd.claim_en) begin
            action_reg[cmd.claim_idx] <= cmd.claim_action;
            period_reg[cmd.claim_idx] <= cmd.claim_period;
            delay_reg[cmd.claim_idx]  <= cmd.claim_delay;
        end else if (cmd.dec_en) begin
            delay_reg[cmd.dec_idx] <= cmd.dec_value;
        end
    end

    assign rd_entry.valid  = valid_reg[rd_idx];
    assign rd_entry.action = action_reg[rd_idx];
    assign rd_entry.period = period_reg[rd_idx];
    assign rd_entry.delay  = delay_reg[rd_idx];
    assign claim_taken     = valid_reg[cmd.claim_idx];

endmodule

// ===== hw/rtl/periodic_task_tick_scheduler_core.sv =====
// Periodic task tick scheduler, top level. Register item: the result passes the DONE state, then the output register.
// Tick item: each slot is visited once, and a slot whose remainder test runs in the shared
// serial remainder unit waits for that unit before the scan moves on.
// One item at a time; the next input is taken in the cycle after the result is handed to the
// output register, which may still wait on m_ready. Synchronous active-low reset clears the
// time count, slot valid bits and all control state; no clearing pass is needed.
module periodic_task_tick_scheduler_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [2:0]               s_slot,
    input  logic [31:0]              s_period,
    input  logic [31:0]              s_first_delay,
    input  logic                     s_callback_present,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_status,
    output logic [7:0]               m_fired_mask
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_VISIT = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]              state_reg, state_next;
    ptts_pkg::idx_t          idx_reg, idx_next;
    ptts_pkg::mask_t         mask_reg, mask_next;
    logic                    status_reg, status_next;
    ptts_pkg::data_t         tick_reg, tick_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_status_reg, m_status_next;
    ptts_pkg::mask_t         m_mask_reg, m_mask_next;

    ptts_pkg::tbl_cmd_t      tbl_cmd;
    ptts_pkg::slot_entry_t   entry;
    logic                    claim_taken;
    logic                    rem_start;
    ptts_pkg::rem_status_t   rem_stat;
    logic                    s_xfer;
    logic                    slot_in_range;
    logic                    last_slot;
    ptts_pkg::mask_t         hit_bit;

    ptts_slot_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (tbl_cmd),
        .rd_idx      (idx_reg),
        .rd_entry    (entry),
        .claim_taken (claim_taken)
    );

    ptts_rem_unit u_rem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (rem_start),
        .dividend   (tick_reg),
        .divisor    (entry.period),
        .rem_status (rem_stat)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_xfer        = s_valid && s_ready;
    assign slot_in_range = (32'(s_slot) < 32'(ptts_pkg::SLOTS));
    assign last_slot     = (idx_reg == ptts_pkg::idx_t'(ptts_pkg::SLOTS - 1));

    // Mask bit of the slot under visit; slots past the mask width get none
    always_comb begin
        hit_bit = '0;
        for (int i = 0; i < ptts_pkg::MASK_W; i++) begin
            if (i < ptts_pkg::SLOTS && idx_reg == ptts_pkg::idx_t'(i)) begin
                hit_bit[i] = 1'b1;
            end
        end
    end

    // Sequencer: claim, slot scan, remainder wait, output hand-off
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        tick_next     = tick_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_mask_next   = m_mask_reg;
        rem_start     = 1'b0;

        tbl_cmd              = '0;
        tbl_cmd.claim_idx    = ptts_pkg::idx_t'(s_slot);
        tbl_cmd.claim_action = s_callback_present;
        tbl_cmd.claim_period = s_period;
        tbl_cmd.claim_delay  = s_first_delay;
        tbl_cmd.dec_idx      = idx_reg;
        tbl_cmd.dec_value    = entry.delay - 1'b1;

        // Drop the output once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_operation == ptts_pkg::OP_REGISTER) begin
                        mask_next = '0;
                        if (slot_in_range && !claim_taken) begin
                            tbl_cmd.claim_en = 1'b1;
                            status_next      = ptts_pkg::STATUS_OK;
                        end else begin
                            status_next      = ptts_pkg::STATUS_BUSY;
                        end
                        state_next = ST_DONE;
                    end else begin
                        tick_next   = tick_reg + 1'b1;
                        idx_next    = '0;
                        mask_next   = '0;
                        status_next = ptts_pkg::STATUS_OK;
                        state_next  = ST_VISIT;
                    end
                end
            end
            ST_VISIT: begin
                if (entry.valid && entry.action && entry.delay == '0
                        && entry.period != '0) begin
                    rem_start  = 1'b1;
                    state_next = ST_WAIT;
                end else begin
                    if (entry.valid && entry.action && entry.delay != '0) begin
                        tbl_cmd.dec_en = 1'b1;
                    end
                    if (last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        mask_next = mask_reg | hit_bit;
                    end
                    if (last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_VISIT;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_mask_next   = mask_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        mask_reg     <= mask_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_mask_reg   <= m_mask_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_fired_mask = m_mask_reg;

endmodule

// ===== hw/rtl/ptts_checker.sv =====
// Port-level checker for the scheduler top level, attached by bind.
// Depends on periodic_task_tick_scheduler_core_defines.svh for the assertion macros.
`include "periodic_task_tick_scheduler_core_defines.svh"

module ptts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_status,
    input logic [7:0] m_fired_mask
);

    // Hold a stalled result
    `PTTS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_fired_mask))

    // A rejected claim never reports fired tasks
    `PTTS_ASSERT_NOW(a_status_mask_excl, m_valid && m_status, m_fired_mask == 8'd0)

    // Busy in the cycle after an input transfer
    `PTTS_ASSERT_NEXT(a_busy_after_xfer, s_valid && s_ready, !s_ready)

    // No result right after reset
    `PTTS_ASSERT_NEXT_ALWAYS(a_reset_quiet, !aresetn, !m_valid)

endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_fired_mask (m_fired_mask)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for periodic_task_tick_scheduler_core.
// Needs ptts_pkg and the core; a local predictor of the slot table checks every result.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic              op;
        ptts_pkg::idx_t    slot;
        ptts_pkg::data_t   period;
        ptts_pkg::data_t   delay;
        logic              action;
    } sched_req_t;

    typedef struct {
        logic              status;
        ptts_pkg::mask_t   mask;
    } sched_outcome_t;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS = 645;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_operation = ptts_pkg::OP_TICK;
    logic [2:0]      s_slot = '0;
    logic [31:0]     s_period = '0;
    logic [31:0]     s_first_delay = '0;
    logic            s_callback_present = 1'b0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic            m_status;
    logic [7:0]      m_fired_mask;

    // Predicted slot table and time count
    logic            claimed [ptts_pkg::SLOTS];
    logic            runs_action [ptts_pkg::SLOTS];
    ptts_pkg::data_t interval [ptts_pkg::SLOTS];
    ptts_pkg::data_t holdoff [ptts_pkg::SLOTS];
    ptts_pkg::data_t now_ticks;

    sched_req_t      pending_requests [$];
    sched_outcome_t  awaited_outcomes [$];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              error_count = 0;
    int              quiet_cycles = 0;

    periodic_task_tick_scheduler_core DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_slot             (s_slot),
        .s_period           (s_period),
        .s_first_delay      (s_first_delay),
        .s_callback_present (s_callback_present),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_fired_mask       (m_fired_mask)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int i = 0; i < ptts_pkg::SLOTS; i++) begin
            claimed[i] = 1'b0;
            runs_action[i] = 1'b0;
            interval[i] = '0;
            holdoff[i] = '0;
        end
        now_ticks = '0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= 50)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Claim a slot or run one tick; return the result the core should produce
    function automatic sched_outcome_t apply_request(logic op, ptts_pkg::idx_t slot,
                                                     ptts_pkg::data_t per,
                                                     ptts_pkg::data_t dly, logic act);
        sched_outcome_t res;
        int i;
        res.status = ptts_pkg::STATUS_OK;
        res.mask = '0;
        if (op == ptts_pkg::OP_REGISTER) begin
            if (int'(slot) >= ptts_pkg::SLOTS || claimed[slot]) begin
                res.status = ptts_pkg::STATUS_BUSY;
            end else begin
                claimed[slot] = 1'b1;
                runs_action[slot] = act;
                interval[slot] = per;
                holdoff[slot] = dly;
            end
        end else begin
            now_ticks = now_ticks + 1;
            for (i = 0; i < ptts_pkg::SLOTS; i++) begin
                if (claimed[i] && runs_action[i]) begin
                    // count the first delay down before any firing
                    if (holdoff[i] != 0)
                        holdoff[i] = holdoff[i] - 1;
                    else if (interval[i] != 0 && (now_ticks % interval[i]) == 0
                             && i < ptts_pkg::MASK_W)
                        res.mask[i] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic sched_req_t make_req(logic op, ptts_pkg::idx_t slot,
                                            ptts_pkg::data_t per, ptts_pkg::data_t dly,
                                            logic act);
        sched_req_t r;
        r.op = op;
        r.slot = slot;
        r.period = per;
        r.delay = dly;
        r.action = act;
        return r;
    endfunction

    // Mostly ticks; registrations favor short periods and delays so slots fire often
    function automatic sched_req_t random_request();
        sched_req_t r;
        r.op = ($urandom_range(3) == 0) ? ptts_pkg::OP_REGISTER : ptts_pkg::OP_TICK;
        r.slot = ptts_pkg::idx_t'($urandom_range(ptts_pkg::SLOTS - 1));
        case ($urandom_range(9))
            0: r.period = '0;
            1, 2, 3: r.period = $urandom;
            default: r.period = $urandom_range(12, 1);
        endcase
        case ($urandom_range(4))
            0: r.delay = $urandom;
            1: r.delay = '0;
            default: r.delay = $urandom_range(6);
        endcase
        r.action = ($urandom_range(4) != 0);
        return r;
    endfunction

    // Block until everything queued has been sent and answered
    task automatic drain_all();
        while (pending_requests.size() != 0 || s_valid || awaited_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    // Stimulus: directed table setup, then three random phases with different idling
    initial begin
        int ph;
        int n;
        // empty table, then the edge cases of registration and firing
        pending_requests.push_back(make_req(ptts_pkg::OP_TICK, 3'd5, '1, '1, 1'b1));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd0, 32'd1, '0, 1'b1));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd0, 32'd5, '0, 1'b1));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd1, '0, 32'd3, 1'b1));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd2, 32'd2, '0, 1'b0));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd7, '1, '1, 1'b1));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd3, 32'd3, 32'd2, 1'b1));
        repeat (6)
            pending_requests.push_back(make_req(ptts_pkg::OP_TICK, '0, '0, '0, 1'b0));
        pending_requests.push_back(make_req(ptts_pkg::OP_REGISTER, 3'd7, '0, '0, 1'b0));
        repeat (2)
            pending_requests.push_back(make_req(ptts_pkg::OP_TICK, 3'd2, 32'd9, 32'd1, 1'b1));

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_requests.push_back(random_request());
            // hold the sender until every result of this phase is back
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Driver: present the next pending request, predict on each input transfer
    always @(posedge aclk) begin : driver
        sched_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_outcomes.push_back(apply_request(s_operation, s_slot, s_period,
                                                         s_first_delay,
                                                         s_callback_present));
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= req.op;
                    s_slot <= req.slot;
                    s_period <= req.period;
                    s_first_delay <= req.delay;
                    s_callback_present <= req.action;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : monitor
        sched_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 32'({m_status, m_fired_mask}), '0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_fired_mask !== want.mask)
                        report_mismatch("fired_mask", 32'(m_fired_mask), 32'(want.mask));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_rem_unit.sv
hw/rtl/ptts_slot_table.sv
hw/rtl/periodic_task_tick_scheduler_core.sv
hw/rtl/ptts_checker.sv
tb/tb_top.sv
